// ===== rtl/rrq_pkg.sv =====
`timescale 1ns / 1ps

package rrq_pkg;

  localparam int unsigned MAX_DEPTH = 1024;
  localparam int unsigned AW        = $clog2(MAX_DEPTH);
  localparam int unsigned DW        = 32;
  localparam int unsigned CAPW      = 11;
  localparam int unsigned OUT_TDW   = 56;

  localparam logic [CAPW-1:0] START_CAP_RESET = CAPW'(50);
  localparam logic [CAPW:0]   MAX_DEPTH_W     = (CAPW+1)'(MAX_DEPTH);

  // Register indexes on the configuration port.
  localparam logic REG_START_CAP = 1'b0;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DEQ,
    ST_COPY,
    ST_PUT,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic            we;
    logic [CAPW-1:0] cap;
  } cfg_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [AW-1:0] raddr;
  } mem_req_t;

  // Capacity is kept between one and the physical depth.
  function automatic logic [CAPW-1:0] limit_capacity(input logic [CAPW-1:0] v);
    logic [CAPW-1:0] r;
    if (v == '0) begin
      r = CAPW'(1);
    end else if ({1'b0, v} > MAX_DEPTH_W) begin
      r = MAX_DEPTH_W[CAPW-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/rrq_ram.sv =====
`timescale 1ns / 1ps

module rrq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/rrq_cfg.sv =====
`timescale 1ns / 1ps

module rrq_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output rrq_pkg::cfg_t cfg_o
);

  import rrq_pkg::*;

  logic [CAPW-1:0] start_cap_q, start_cap_d;
  logic            wr_en;
  logic            sel_start;

  assign pready    = 1'b1;
  assign sel_start = (paddr[2] == REG_START_CAP);
  assign wr_en     = psel & penable & pwrite & pready & sel_start;

  always_comb begin
    start_cap_d = start_cap_q;
    if (wr_en) begin
      start_cap_d = pwdata[CAPW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_cap_q <= START_CAP_RESET;
    end else begin
      start_cap_q <= start_cap_d;
    end
  end

  assign prdata    = sel_start ? {{(32-CAPW){1'b0}}, start_cap_q} : '0;
  assign cfg_o.we  = wr_en;
  assign cfg_o.cap = limit_capacity(pwdata[CAPW-1:0]);

endmodule

// ===== rtl/rrq_ctrl.sv =====
`timescale 1ns / 1ps

module rrq_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rrq_pkg::cfg_t         cfg_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [31:0]           s_axis_tdata,
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [55:0]           m_axis_tdata,
  output logic [1:0]            m_axis_tuser,
  output rrq_pkg::mem_req_t     mem_req_o [2],
  input  logic [rrq_pkg::DW-1:0] mem_rdata_i [2]
);

  import rrq_pkg::*;

  state_e          state_q, state_d;
  op_e             op_q, op_d;
  logic [DW-1:0]   din_q, din_d;
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d, src_q, src_d;
  logic [CAPW-1:0] cnt_q, cnt_d, cap_q, cap_d, newcap_q, newcap_d;
  logic [CAPW-1:0] icnt_q, icnt_d, ocnt_q, ocnt_d;
  logic            bank_q, bank_d, pend_q, pend_d;
  logic [DW-1:0]   res_data_q, res_data_d;
  status_e         res_status_q, res_status_d;
  logic            m_valid_q, m_valid_d;
  logic [55:0]     m_data_q, m_data_d;
  logic [1:0]      m_user_q, m_user_d;
  mem_req_t        req_act, req_oth;
  logic [DW-1:0]   rdata_act;
  logic            slot_free, accept;
  logic [CAPW-1:0] cnt_dec;
  logic [AW-1:0]   rd_inc;
  logic [CAPW:0]   cap_dbl;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx,
                                             input logic [CAPW-1:0] cap);
    logic [CAPW-1:0] nxt;
    nxt = CAPW'(idx) + CAPW'(1);
    return (nxt == cap) ? '0 : nxt[AW-1:0];
  endfunction

  assign slot_free     = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) || ((state_q == ST_OUT) && slot_free);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rdata_act     = mem_rdata_i[bank_q];
  assign cnt_dec       = cnt_q - CAPW'(1);
  assign rd_inc        = wrap_inc(rd_q, cap_q);
  assign cap_dbl       = {cap_q, 1'b0};

  // The active bank holds the queue; a resize copies it in order into the
  // other bank and then swaps the two.
  always_comb begin
    mem_req_o[0] = bank_q ? req_oth : req_act;
    mem_req_o[1] = bank_q ? req_act : req_oth;
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    din_d        = din_q;
    wr_d         = wr_q;
    rd_d         = rd_q;
    src_d        = src_q;
    cnt_d        = cnt_q;
    cap_d        = cap_q;
    newcap_d     = newcap_q;
    icnt_d       = icnt_q;
    ocnt_d       = ocnt_q;
    bank_d       = bank_q;
    pend_d       = 1'b0;
    res_data_d   = res_data_q;
    res_status_d = res_status_q;
    m_data_d     = m_data_q;
    m_user_d     = m_user_q;
    m_valid_d    = m_valid_q && !m_axis_tready;
    req_act      = '0;
    req_oth      = '0;

    unique case (state_q)
      ST_IDLE: begin
      end
      ST_EXEC: begin
        res_data_d   = '0;
        res_status_d = STATUS_OK;
        if (op_q == OP_ENQ) begin
          if (cnt_q < cap_q) begin
            req_act.we    = 1'b1;
            req_act.waddr = wr_q;
            req_act.wdata = din_q;
            wr_d          = wrap_inc(wr_q, cap_q);
            cnt_d         = cnt_q + CAPW'(1);
            state_d       = ST_OUT;
          end else if (cap_dbl > MAX_DEPTH_W) begin
            res_status_d = STATUS_FULL;
            state_d      = ST_OUT;
          end else begin
            newcap_d = cap_dbl[CAPW-1:0];
            src_d    = rd_q;
            icnt_d   = '0;
            ocnt_d   = '0;
            state_d  = ST_COPY;
          end
        end else begin
          if (cnt_q == '0) begin
            res_status_d = STATUS_EMPTY;
            state_d      = ST_OUT;
          end else begin
            req_act.raddr = rd_q;
            state_d       = ST_DEQ;
          end
        end
      end
      ST_DEQ: begin
        res_data_d = rdata_act;
        rd_d       = rd_inc;
        cnt_d      = cnt_dec;
        if ((cnt_dec != '0) && (cnt_dec <= (cap_q >> 2))) begin
          newcap_d = cap_q >> 1;
          src_d    = rd_inc;
          icnt_d   = '0;
          ocnt_d   = '0;
          state_d  = ST_COPY;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_COPY: begin
        // Read one word per cycle; the word read last cycle is written now.
        if (icnt_q < cnt_q) begin
          req_act.raddr = src_q;
          src_d         = wrap_inc(src_q, cap_q);
          icnt_d        = icnt_q + CAPW'(1);
          pend_d        = 1'b1;
        end
        if (pend_q) begin
          req_oth.we    = 1'b1;
          req_oth.waddr = ocnt_q[AW-1:0];
          req_oth.wdata = rdata_act;
          ocnt_d        = ocnt_q + CAPW'(1);
        end
        if ((icnt_q == cnt_q) && !pend_q) begin
          bank_d  = !bank_q;
          cap_d   = newcap_q;
          rd_d    = '0;
          wr_d    = cnt_q[AW-1:0];
          state_d = (op_q == OP_ENQ) ? ST_PUT : ST_OUT;
        end
      end
      ST_PUT: begin
        req_act.we    = 1'b1;
        req_act.waddr = wr_q;
        req_act.wdata = din_q;
        wr_d          = wrap_inc(wr_q, cap_q);
        cnt_d         = cnt_q + CAPW'(1);
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        if (slot_free) begin
          m_valid_d = 1'b1;
          m_data_d  = {{(OUT_TDW-DW-2*CAPW){1'b0}}, cnt_q, cap_q, res_data_q};
          m_user_d  = res_status_q;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (accept) begin
      op_d    = op_e'(s_axis_tuser[0]);
      din_d   = s_axis_tdata;
      state_d = ST_EXEC;
    end

    // Write configuration only in idle (unchecked); it empties the queue.
    if (cfg_i.we) begin
      wr_d  = '0;
      rd_d  = '0;
      cnt_d = '0;
      cap_d = cfg_i.cap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wr_q      <= '0;
      rd_q      <= '0;
      cnt_q     <= '0;
      cap_q     <= limit_capacity(START_CAP_RESET);
      bank_q    <= 1'b0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_q      <= wr_d;
      rd_q      <= rd_d;
      cnt_q     <= cnt_d;
      cap_q     <= cap_d;
      bank_q    <= bank_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    din_q        <= din_d;
    src_q        <= src_d;
    newcap_q     <= newcap_d;
    icnt_q       <= icnt_d;
    ocnt_q       <= ocnt_d;
    res_data_q   <= res_data_d;
    res_status_q <= res_status_d;
    m_data_q     <= m_data_d;
    m_user_q     <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

// ===== rtl/resizable_ring_queue.sv =====
`timescale 1ns / 1ps

// Resizable ring queue of 32-bit words held in two 1024-entry memories.
// Input channel (s_axis): tuser[0] selects enqueue (0) or dequeue (1), tdata
// carries the word to enqueue. Output channel (m_axis): one result per input
// transfer, in order, with the dequeued word, capacity and count in tdata and
// the status in tuser. APB register 0 sets the start capacity; writing it
// empties the queue, and the user must write it only while no transfer is in
// flight; the block itself does not enforce this. An enqueue without resize
// passes through states EXEC and OUT, a non-empty dequeue EXEC, DEQ and OUT,
// before the output register takes the result. A new input is taken only in
// IDLE or, with a free output register, in OUT; the single memory read port of
// the active bank and the read-modify sequence set this. A resize (doubling on
// a full enqueue if twice the capacity fits the depth, halving when a dequeue
// leaves a quarter or less but not none) copies the stored words one per cycle
// into the other bank; a grow then writes the new word in state PUT. Reset
// empties the queue and sets the capacity to 50; memory contents are left as
// they are and no clearing pass is needed. When the receiver stalls, the result
// holds in the output register; one more input transfer is still taken and
// worked through; further inputs are refused until the held result is taken.

module resizable_ring_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // data_in[31:0]
  input  logic [0:0]  s_axis_tuser,  // operation[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // data_out[31:0], capacity_now[42:32],
                                     // count_now[53:43], zero[55:54]
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import rrq_pkg::*;

  cfg_t          cfg;
  mem_req_t      mem_req [2];
  logic [DW-1:0] mem_rdata [2];

  rrq_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rrq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .mem_req_o     (mem_req),
    .mem_rdata_i   (mem_rdata)
  );

  rrq_ram #(
    .Width (DW),
    .Depth (MAX_DEPTH)
  ) u_ram0 (
    .clk_i   (clk_i),
    .we_i    (mem_req[0].we),
    .waddr_i (mem_req[0].waddr),
    .wdata_i (mem_req[0].wdata),
    .raddr_i (mem_req[0].raddr),
    .rdata_o (mem_rdata[0])
  );

  rrq_ram #(
    .Width (DW),
    .Depth (MAX_DEPTH)
  ) u_ram1 (
    .clk_i   (clk_i),
    .we_i    (mem_req[1].we),
    .waddr_i (mem_req[1].waddr),
    .wdata_i (mem_req[1].wdata),
    .raddr_i (mem_req[1].raddr),
    .rdata_o (mem_rdata[1])
  );

endmodule

// ===== rtl/rrq_checker.sv =====
`timescale 1ns / 1ps

module rrq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  import rrq_pkg::*;

  // A stalled result must not change.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // The count never exceeds the capacity, and the capacity is never zero.
  a_count_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[53:43] <= m_axis_tdata[42:32]) &&
                      (m_axis_tdata[42:32] != '0))
    else $error("count above capacity or capacity zero");

  // An empty dequeue leaves an empty queue and returns zero.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STATUS_EMPTY) |->
      (m_axis_tdata[31:0] == '0) && (m_axis_tdata[53:43] == '0))
    else $error("empty status with data or stored words");

  // A refused enqueue happens only on a full queue that cannot double.
  a_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == STATUS_FULL) |->
      (m_axis_tdata[53:43] == m_axis_tdata[42:32]) &&
      ({m_axis_tdata[42:32], 1'b0} > MAX_DEPTH_W) && (m_axis_tdata[31:0] == '0))
    else $error("enqueue refused although it could grow");

  // Input is never ready in the cycle after an input transfer.
  a_gap_after_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken on two edges in a row");

endmodule

bind resizable_ring_queue rrq_checker u_rrq_checker (.*);

// ===== sim/resizable_ring_queue_tb.sv =====
`timescale 1ns / 1ps

module resizable_ring_queue_tb;
  import rrq_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400_000;
  localparam int unsigned SETTLE_CYCLES = 6;

  typedef struct {
    logic [31:0] data;
    status_e     status;
    logic [10:0] capacity;
    logic [10:0] count;
  } queue_result_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        s_axis_tvalid  = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata   = '0;  // data_in[31:0]
  logic [0:0]  s_axis_tuser   = '0;  // operation[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready  = 1'b0;
  logic [55:0] m_axis_tdata;         // data_out[31:0], capacity_now[42:32],
                                     // count_now[53:43], zero[55:54]
  logic [1:0]  m_axis_tuser;         // status[1:0]
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [2:0]  paddr          = '0;
  logic [31:0] pwdata         = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted queue contents and settings.
  logic [31:0]   stored_words[$];
  int unsigned   cur_capacity  = START_CAP_RESET;
  queue_result_t pending_results[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req       = 0;
  int unsigned hold_left      = 0;
  int unsigned mismatches     = 0;

  resizable_ring_queue dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    for (int unsigned cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // Receiver: a requested hold-off is counted down here, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    queue_result_t want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: tdata=%h tuser=%h", m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[31:0] !== want.data || m_axis_tuser !== want.status ||
            m_axis_tdata[42:32] !== want.capacity || m_axis_tdata[53:43] !== want.count ||
            m_axis_tdata[55:54] !== 2'b00) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected data=%h status=%0d cap=%0d count=%0d",
                     want.data, want.status, want.capacity, want.count);
            $display("          got data=%h status=%0d cap=%0d count=%0d pad=%b",
                     m_axis_tdata[31:0], m_axis_tuser, m_axis_tdata[42:32],
                     m_axis_tdata[53:43], m_axis_tdata[55:54]);
          end
        end
      end
    end
  end

  // Applies one operation to the predicted queue and records the result it should give.
  task automatic predict_queue_op(input op_e op, input logic [31:0] word);
    queue_result_t r;
    r.data   = '0;
    r.status = STATUS_OK;
    if (op == OP_ENQ) begin
      if (stored_words.size() >= cur_capacity) begin
        if (cur_capacity * 2 > MAX_DEPTH) r.status = STATUS_FULL;
        else cur_capacity = cur_capacity * 2;
      end
      if (r.status == STATUS_OK) stored_words.push_back(word);
    end else if (stored_words.size() == 0) begin
      r.status = STATUS_EMPTY;
    end else begin
      r.data = stored_words.pop_front();
      if (stored_words.size() > 0 && stored_words.size() <= cur_capacity / 4)
        cur_capacity = cur_capacity / 2;
    end
    r.capacity = cur_capacity[10:0];
    r.count    = 11'(stored_words.size());
    pending_results.push_back(r);
  endtask

  // Called and returns at a falling edge; valid stays high for a following item.
  task automatic send_item(input op_e op, input logic [31:0] word,
                           input int unsigned hold_after = 0);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    predict_queue_op(op, word);
    if (hold_after != 0) hold_req = hold_after;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_start_capacity(input logic [10:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_START_CAP, 2'b00};
    pwdata  <= {21'b0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    stored_words.delete();
    if (value == 0) cur_capacity = 1;
    else if (value > MAX_DEPTH) cur_capacity = MAX_DEPTH;
    else cur_capacity = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  function automatic logic [31:0] pick_word();
    int unsigned r;
    r = $urandom_range(15);
    if (r == 0) return 32'h8000_0000;
    if (r == 1) return 32'h7fff_ffff;
    return $urandom;
  endfunction

  // Capacity starts at its reset value; empty dequeues and extreme words.
  task automatic test_reset_capacity_extremes();
    logic [31:0] words[6];
    words = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
              32'haaaa_aaaa, 32'h5555_5555};
    set_idling(0, 0);
    send_item(OP_DEQ, 32'hdead_beef);
    foreach (words[i]) send_item(OP_ENQ, words[i]);
    foreach (words[i]) send_item(OP_DEQ, 32'h0);
    send_item(OP_DEQ, 32'h0);
  endtask

  // A zero register gives capacity one; growth and shrink from the bottom.
  task automatic test_capacity_floor();
    wait_drained();
    write_start_capacity(11'd0);
    for (int i = 0; i < 3; i++) send_item(OP_ENQ, pick_word());
    for (int i = 0; i < 4; i++) send_item(OP_DEQ, 32'h0);
    wait_drained();
    write_start_capacity(11'd1);
    send_item(OP_ENQ, pick_word());
    send_item(OP_DEQ, 32'h0);
  endtask

  // Register values at and above the physical depth.
  task automatic test_capacity_ceiling();
    wait_drained();
    write_start_capacity(11'h7ff);
    send_item(OP_ENQ, pick_word());
    send_item(OP_DEQ, 32'h0);
    wait_drained();
    write_start_capacity(11'(MAX_DEPTH));
    send_item(OP_ENQ, pick_word());
    send_item(OP_DEQ, 32'h0);
  endtask

  // Above half the depth a full queue cannot double, so enqueues get refused.
  // The receiver holds off for a while so the block backs up its input.
  task automatic test_refused_at_max();
    wait_drained();
    write_start_capacity(11'd513);
    set_idling(23, 23);
    for (int i = 0; i < 516; i++) send_item(OP_ENQ, pick_word(), (i == 50) ? 300 : 0);
    wait_drained();
    set_idling(0, 75);
    for (int i = 0; i < 20; i++) send_item(op_e'(i % 2 == 0), pick_word());
  endtask

  // Bursts leaning toward enqueue or dequeue make the capacity climb and fall.
  task automatic test_random_traffic();
    int unsigned send_pct[4];
    int unsigned recv_pct[4];
    int unsigned burst_left;
    int unsigned enq_bias;
    int unsigned r;
    op_e         op;
    send_pct   = '{0, 75, 0, 23};
    recv_pct   = '{0, 0, 75, 23};
    burst_left = 0;
    enq_bias   = 50;
    for (int m = 0; m < 4; m++) begin
      for (int seg = 0; seg < 2; seg++) begin
        wait_drained();
        set_idling(send_pct[m], recv_pct[m]);
        r = $urandom_range(9);
        if (r < 7) write_start_capacity(11'($urandom_range(1, 40)));
        else write_start_capacity(11'($urandom_range(0, 2047)));
        for (int n = 0; n < 36; n++) begin
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            enq_bias   = $urandom_range(1) ? 80 : 25;
          end
          burst_left--;
          op = ($urandom_range(99) < enq_bias) ? OP_ENQ : OP_DEQ;
          send_item(op, pick_word());
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_capacity_extremes();
    test_capacity_floor();
    test_capacity_ceiling();
    test_refused_at_max();
    test_random_traffic();
    wait_drained();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
